[rtl/vec3_fixed_point_alu_unit_defines.svh]
// Assertion macros shared by the vector ALU.
`ifndef VEC3_FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define VEC3_FIXED_POINT_ALU_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vfa_pkg.sv]
package vfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int LANES     = 3;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int SQ_W      = 2 * WORD_BITS + 2;
  localparam int ROOT_W    = WORD_BITS + 1;
  localparam int DIVN_W    = WORD_BITS + FRAC_BITS;
  localparam int WIDE_W    = 2 * WORD_BITS + 3;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_SCALE  = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_DOT    = 4'd4;
  localparam logic [3:0] OP_CROSS  = 4'd5;
  localparam logic [3:0] OP_LENSQ  = 4'd6;
  localparam logic [3:0] OP_LEN    = 4'd7;
  localparam logic [3:0] OP_NORM   = 4'd8;
  localparam logic [3:0] OP_EQUAL  = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [3:0] op;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      scalar_in;
  } in_t;

  typedef struct packed {
    word_t      r_x;
    word_t      r_y;
    word_t      r_z;
    word_t      r_scalar;
    logic       is_equal;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
  } prod_t;

  typedef struct packed {
    word_t v;
    logic  f;
  } sat_t;

  // What an item carries alongside the root and divide pipelines.
  typedef struct packed {
    logic [3:0]                      op;
    logic [LANES-1:0]                a_neg;
    logic [LANES-1:0][WORD_BITS-1:0] a_mag;
    logic                            s_neg;
    logic                            s_zero;
    logic [WORD_BITS-1:0]            s_mag;
    out_t                            res;
  } carry_t;

  // Clamp a wide signed value to the word range and report clamping.
  function automatic sat_t sat_word(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    logic fits;
    fits = (&v[WIDE_W-1:WORD_BITS-1]) | ~(|v[WIDE_W-1:WORD_BITS-1]);
    r.f = ~fits;
    if (fits) begin
      r.v = v[WORD_BITS-1:0];
    end else if (v[WIDE_W-1]) begin
      r.v = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r.v = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/vfa_mul_lane.sv]
module vfa_mul_lane (
  input  logic           clk,
  input  vfa_pkg::word_t x0,
  input  vfa_pkg::word_t y0,
  input  vfa_pkg::word_t x1,
  input  vfa_pkg::word_t y1,
  output vfa_pkg::prod_t prod
);
  import vfa_pkg::*;

  prod_t prod_r;
  prod_t prod_nxt;

  always_comb begin
    prod_nxt.pa = PROD_W'(x0) * PROD_W'(y0);
    prod_nxt.pb = PROD_W'(x1) * PROD_W'(y1);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[rtl/vfa_sqrt.sv]
module vfa_sqrt #(
  parameter int ROOT_BITS = 33
) (
  input  logic                     clk,
  input  logic [2*ROOT_BITS-1:0]   radicand,
  output logic [ROOT_BITS-1:0]     root
);
  localparam int RAD_W = 2 * ROOT_BITS;
  localparam int REM_W = ROOT_BITS + 3;

  logic [REM_W-1:0]     rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic [RAD_W-1:0]     rad_r  [ROOT_BITS];

  // One result bit per stage, two radicand bits consumed per stage.
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [REM_W-1:0]     rem_in;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic [ROOT_BITS-1:0] root_in;
    logic [RAD_W-1:0]     rad_in;
    logic                 ge;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*k -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
      root_r[k] <= {root_in[ROOT_BITS-2:0], ge};
      rad_r[k]  <= rad_in;
    end
  end

  assign root = root_r[ROOT_BITS-1];

endmodule

[rtl/vfa_div_lane.sv]
module vfa_div_lane #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end
    assign trial = {rem_in, num_in[NUM_W-1-k]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r[k] <= num_in;
      den_r[k] <= den_in;
      quo_r[k] <= {quo_in[NUM_W-2:0], ge};
    end
  end

  assign quo = quo_r[NUM_W-1];

endmodule

[rtl/vfa_delay.sv]
module vfa_delay #(
  parameter int DEPTH  = 4,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_in,
  input  logic [DATA_W-1:0] dat_in,
  output logic              vld_out,
  output logic [DATA_W-1:0] dat_out
);
  logic              vld_r [DEPTH];
  logic [DATA_W-1:0] dat_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= vld_in;
      for (int i = 1; i < DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dat_r[0] <= dat_in;
    for (int i = 1; i < DEPTH; i++) begin
      dat_r[i] <= dat_r[i-1];
    end
  end

  assign vld_out = vld_r[DEPTH-1];
  assign dat_out = dat_r[DEPTH-1];

endmodule

[rtl/vec3_fixed_point_alu_unit.sv]
`include "vec3_fixed_point_alu_unit_defines.svh"

// Three-component vector ALU in signed Q16.16. A request is taken on every
// clock edge where start is high; busy never rises, so one request per cycle
// is sustained. Every request produces exactly one result, shown for one
// cycle with out_strobe high, in request order. The receiver cannot stall
// the block and must take each result in the cycle it appears. The
// pipeline has 85 registers: one input register (loaded on the accepting
// edge), one multiply stage, one merge stage, a 33-stage square root (one
// root bit per stage), a 48-stage divider per lane (one quotient bit per
// stage) and one output register. All opcodes travel the full depth.
module vec3_fixed_point_alu_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  vfa_pkg::in_t  in_item,
  output logic          out_strobe,
  output vfa_pkg::out_t out_result
);
  import vfa_pkg::*;

  localparam int LAT_ROOT = ROOT_W;
  localparam int LAT_DIV  = DIVN_W;

  // The pipeline always advances, so requests are never refused.
  assign busy = 1'b0;

  // Stage 0: capture the request.
  logic  v0_r;
  in_t   in0_r;
  word_t a0 [LANES];
  word_t b0 [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    in0_r <= in_item;
  end

  assign a0[0] = in0_r.a_x;
  assign a0[1] = in0_r.a_y;
  assign a0[2] = in0_r.a_z;
  assign b0[0] = in0_r.b_x;
  assign b0[1] = in0_r.b_y;
  assign b0[2] = in0_r.b_z;

  // Stage 1: each lane forms two products. The first product is the
  // per-component term the opcode calls for; the second is the subtracted
  // half of the cross product.
  prod_t prod [LANES];
  logic  v1_r;
  in_t   in1_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int J1 = (i + 1) % LANES;
    localparam int J2 = (i + 2) % LANES;
    word_t x0_sel;
    word_t y0_sel;
    always_comb begin
      x0_sel = (in0_r.op == OP_CROSS) ? a0[J1] : a0[i];
      case (in0_r.op)
        OP_SCALE: y0_sel = in0_r.scalar_in;
        OP_CROSS: y0_sel = b0[J2];
        OP_LENSQ, OP_LEN, OP_NORM: y0_sel = a0[i];
        default:  y0_sel = b0[i];
      endcase
    end
    vfa_mul_lane u_mul (
      .clk  (clk),
      .x0   (x0_sel),
      .y0   (y0_sel),
      .x1   (a0[J2]),
      .y1   (b0[J1]),
      .prod (prod[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    in1_r <= in0_r;
  end

  // Stage 2: merge the lanes. Everything but length, divide and normalize
  // is finished here; those three wait for the root and divide pipelines.
  word_t                    a1 [LANES];
  word_t                    b1 [LANES];
  logic signed [WIDE_W-1:0] vv [LANES];
  logic signed [WIDE_W-1:0] sv;
  sat_t                     sr [LANES];
  sat_t                     ss;
  logic [SQ_W-1:0]          sq_nxt;
  logic [SQ_W-1:0]          sq2_r;
  carry_t                   c2_nxt;
  carry_t                   c2_r;
  logic                     v2_r;

  assign a1[0] = in1_r.a_x;
  assign a1[1] = in1_r.a_y;
  assign a1[2] = in1_r.a_z;
  assign b1[0] = in1_r.b_x;
  assign b1[1] = in1_r.b_y;
  assign b1[2] = in1_r.b_z;

  always_comb begin
    sq_nxt = SQ_W'($unsigned(prod[0].pa)) + SQ_W'($unsigned(prod[1].pa))
           + SQ_W'($unsigned(prod[2].pa));
    for (int i = 0; i < LANES; i++) begin
      case (in1_r.op)
        OP_ADD:   vv[i] = WIDE_W'(a1[i]) + WIDE_W'(b1[i]);
        OP_SUB:   vv[i] = WIDE_W'(a1[i]) - WIDE_W'(b1[i]);
        OP_SCALE: vv[i] = WIDE_W'(prod[i].pa) >>> FRAC_BITS;
        OP_CROSS: vv[i] = (WIDE_W'(prod[i].pa) - WIDE_W'(prod[i].pb)) >>> FRAC_BITS;
        default:  vv[i] = '0;
      endcase
      sr[i] = sat_word(vv[i]);
    end
    case (in1_r.op)
      OP_DOT:   sv = (WIDE_W'(prod[0].pa) + WIDE_W'(prod[1].pa) + WIDE_W'(prod[2].pa))
                     >>> FRAC_BITS;
      OP_LENSQ: sv = $signed(WIDE_W'(sq_nxt >> FRAC_BITS));
      default:  sv = '0;
    endcase
    ss = sat_word(sv);

    c2_nxt        = '0;
    c2_nxt.op     = in1_r.op;
    for (int i = 0; i < LANES; i++) begin
      c2_nxt.a_neg[i] = a1[i][WORD_BITS-1];
      c2_nxt.a_mag[i] = a1[i][WORD_BITS-1] ? WORD_BITS'(-a1[i]) : WORD_BITS'(a1[i]);
    end
    c2_nxt.s_neg  = in1_r.scalar_in[WORD_BITS-1];
    c2_nxt.s_zero = (in1_r.scalar_in == '0);
    c2_nxt.s_mag  = in1_r.scalar_in[WORD_BITS-1] ? WORD_BITS'(-in1_r.scalar_in)
                                                 : WORD_BITS'(in1_r.scalar_in);
    case (in1_r.op)
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        c2_nxt.res.r_x    = sr[0].v;
        c2_nxt.res.r_y    = sr[1].v;
        c2_nxt.res.r_z    = sr[2].v;
        c2_nxt.res.status = (sr[0].f | sr[1].f | sr[2].f) ? ST_SAT : ST_OK;
      end
      OP_DOT, OP_LENSQ: begin
        c2_nxt.res.r_scalar = ss.v;
        c2_nxt.res.status   = ss.f ? ST_SAT : ST_OK;
      end
      OP_EQUAL: begin
        c2_nxt.res.is_equal = (a1[0] == b1[0]) && (a1[1] == b1[1]) && (a1[2] == b1[2]);
      end
      default: begin
        c2_nxt.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq2_r <= sq_nxt;
    c2_r  <= c2_nxt;
  end

  // Square root of the summed squares, alongside a matching delay line.
  logic [ROOT_W-1:0] root;
  carry_t            c3;
  carry_t            c3_fix;
  logic              v3;
  sat_t              len_sat;

  vfa_sqrt #(.ROOT_BITS(ROOT_W)) u_sqrt (
    .clk      (clk),
    .radicand (sq2_r),
    .root     (root)
  );

  vfa_delay #(.DEPTH(LAT_ROOT), .DATA_W($bits(carry_t))) u_dly_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (v2_r),
    .dat_in  (c2_r),
    .vld_out (v3),
    .dat_out (c3)
  );

  // The length result is final as soon as the root is known.
  always_comb begin
    len_sat = sat_word($signed(WIDE_W'(root)));
    c3_fix  = c3;
    if (c3.op == OP_LEN) begin
      c3_fix.res.r_scalar = len_sat.v;
      c3_fix.res.status   = len_sat.f ? ST_SAT : ST_OK;
    end
  end

  // Divide each magnitude by the scalar or by the length.
  logic [ROOT_W-1:0] den;
  logic [DIVN_W-1:0] quo [LANES];
  carry_t            c5;
  logic              lz5;
  logic              v5;

  assign den = (c3.op == OP_NORM) ? root : ROOT_W'(c3.s_mag);

  for (genvar i = 0; i < LANES; i++) begin : g_div
    vfa_div_lane #(.NUM_W(DIVN_W), .DEN_W(ROOT_W)) u_div (
      .clk (clk),
      .num ({c3.a_mag[i], {FRAC_BITS{1'b0}}}),
      .den (den),
      .quo (quo[i])
    );
  end

  vfa_delay #(.DEPTH(LAT_DIV), .DATA_W($bits(carry_t) + 1)) u_dly_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (v3),
    .dat_in  ({(root == '0), c3_fix}),
    .vld_out (v5),
    .dat_out ({lz5, c5})
  );

  // Final stage: sign and clamp the quotients, then register the result.
  logic signed [WIDE_W-1:0] qv [LANES];
  sat_t                     qs [LANES];
  out_t                     out_nxt;
  out_t                     out_r;
  logic                     out_strobe_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qv[i] = (c5.a_neg[i] ^ ((c5.op == OP_DIV) & c5.s_neg))
            ? -$signed(WIDE_W'(quo[i])) : $signed(WIDE_W'(quo[i]));
      qs[i] = sat_word(qv[i]);
    end
    out_nxt = c5.res;
    case (c5.op)
      OP_DIV: begin
        out_nxt = '0;
        if (c5.s_zero) begin
          out_nxt.status = ST_DIV0;
        end else begin
          out_nxt.r_x    = qs[0].v;
          out_nxt.r_y    = qs[1].v;
          out_nxt.r_z    = qs[2].v;
          out_nxt.status = (qs[0].f | qs[1].f | qs[2].f) ? ST_SAT : ST_OK;
        end
      end
      OP_NORM: begin
        out_nxt = '0;
        if (!lz5) begin
          out_nxt.r_x = qs[0].v;
          out_nxt.r_y = qs[1].v;
          out_nxt.r_z = qs[2].v;
        end
      end
      default: begin
        out_nxt = c5.res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v5;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  // A division by zero always comes with a zero vector.
  `VFA_ASSERT_SAME(a_div0_zero, out_strobe && out_result.status == ST_DIV0,
    out_result.r_x == '0 && out_result.r_y == '0 && out_result.r_z == '0,
    "division by zero result is not the zero vector")

  // The equality flag only comes from the compare, which never saturates.
  `VFA_ASSERT_SAME(a_eq_clean, out_strobe && out_result.is_equal,
    out_result.status == ST_OK && out_result.r_scalar == '0,
    "equality result carries other fields")

  // A captured request always reaches the multiply stage.
  `VFA_ASSERT_NEXT(a_stage_adv, v0_r, v1_r, "request lost between capture and multiply")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the three-component vector ALU. A queue of requests is built
// by an initial block (a directed set first, then random requests), and a
// clocked driver presents them on the start/busy handshake with random idle
// bursts. Every accepted request is run through a local predictor of the
// fixed-point arithmetic, and the expected result is queued. A clocked
// monitor compares every strobed result field by field with the oldest
// expectation.
module tb_top;
  import vfa_pkg::*;

  logic clk = 1'b1;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_strobe;
  out_t out_result;

  vec3_fixed_point_alu_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   fail_count = 0;
  bit   stim_done = 0;
  int   idle_left = 0;
  int   reqs_sent = 0;
  int   quiet_from;

  localparam longint WMAX_L = 64'sd2147483647;
  localparam longint WMIN_L = -64'sd2147483648;
  localparam longint ONE_L  = 64'sd65536;

  // Clamp to the word range; the flag records any clamping.
  function automatic word_t clamp_word(input longint v, inout bit flag);
    if (v > WMAX_L) begin
      flag = 1;
      return word_t'(WMAX_L);
    end
    if (v < WMIN_L) begin
      flag = 1;
      return word_t'(WMIN_L);
    end
    return word_t'(v);
  endfunction

  // Floor of a signed product sum divided by 2^16, in 128 bits so that no
  // intermediate can overflow.
  function automatic longint floor_q(input logic signed [127:0] v);
    logic signed [127:0] t;
    t = v >>> FRAC_BITS;
    return longint'(t);
  endfunction

  function automatic longint floor_root(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic out_t predict_vector_op(input in_t q);
    out_t r;
    longint a[3], b[3], s, len;
    logic signed [127:0] acc, sq;
    bit flag;
    a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
    b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
    s = q.scalar_in;
    flag = 0;
    r = '0;
    sq = 128'(a[0] * a[0]) + 128'(a[1] * a[1]) + 128'(a[2] * a[2]);
    case (q.op)
      OP_ADD: begin
        r.r_x = clamp_word(a[0] + b[0], flag);
        r.r_y = clamp_word(a[1] + b[1], flag);
        r.r_z = clamp_word(a[2] + b[2], flag);
      end
      OP_SUB: begin
        r.r_x = clamp_word(a[0] - b[0], flag);
        r.r_y = clamp_word(a[1] - b[1], flag);
        r.r_z = clamp_word(a[2] - b[2], flag);
      end
      OP_SCALE: begin
        r.r_x = clamp_word(floor_q(128'(a[0] * s)), flag);
        r.r_y = clamp_word(floor_q(128'(a[1] * s)), flag);
        r.r_z = clamp_word(floor_q(128'(a[2] * s)), flag);
      end
      OP_DIV: begin
        if (s == 0) begin
          r.status = ST_DIV0;
        end else begin
          // SystemVerilog integer division truncates toward zero.
          r.r_x = clamp_word((a[0] * ONE_L) / s, flag);
          r.r_y = clamp_word((a[1] * ONE_L) / s, flag);
          r.r_z = clamp_word((a[2] * ONE_L) / s, flag);
        end
      end
      OP_DOT: begin
        acc = 128'(a[0] * b[0]) + 128'(a[1] * b[1]) + 128'(a[2] * b[2]);
        r.r_scalar = clamp_word(floor_q(acc), flag);
      end
      OP_CROSS: begin
        r.r_x = clamp_word(floor_q(128'(a[1] * b[2]) - 128'(a[2] * b[1])), flag);
        r.r_y = clamp_word(floor_q(128'(a[2] * b[0]) - 128'(a[0] * b[2])), flag);
        r.r_z = clamp_word(floor_q(128'(a[0] * b[1]) - 128'(a[1] * b[0])), flag);
      end
      OP_LENSQ: r.r_scalar = clamp_word(floor_q(sq), flag);
      OP_LEN:   r.r_scalar = clamp_word(floor_root(sq), flag);
      OP_NORM: begin
        len = floor_root(sq);
        if (len != 0) begin
          r.r_x = word_t'((a[0] * ONE_L) / len);
          r.r_y = word_t'((a[1] * ONE_L) / len);
          r.r_z = word_t'((a[2] * ONE_L) / len);
        end
      end
      OP_EQUAL: r.is_equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      default: ;
    endcase
    if (flag) r.status = ST_SAT;
    return r;
  endfunction

  // Random word biased toward the extremes and small values.
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return word_t'($urandom_range(0, 8)) - 4;
      3: return word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return 32'sh00010000;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic in_t make_req(input logic [3:0] op, input word_t ax, input word_t ay,
                                   input word_t az, input word_t bx, input word_t by,
                                   input word_t bz, input word_t sc);
    in_t q;
    q.op = op; q.a_x = ax; q.a_y = ay; q.a_z = az;
    q.b_x = bx; q.b_y = by; q.b_z = bz; q.scalar_in = sc;
    return q;
  endfunction

  initial begin
    in_t q;
    word_t mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    // Directed requests: extremes, each opcode, divide by zero, normalize of
    // zero, equal and unequal vectors, and the unused opcodes.
    pending_reqs.push_back(make_req(OP_ADD, mx, mn, 1, mx, mn, -1, 0));
    pending_reqs.push_back(make_req(OP_SUB, mn, mx, 0, 1, -1, 0, 0));
    pending_reqs.push_back(make_req(OP_SCALE, mx, mn, 32'sh10000, 0, 0, 0, mx));
    pending_reqs.push_back(make_req(OP_SCALE, -3, 5, 32'sh18000, 0, 0, 0, -1));
    pending_reqs.push_back(make_req(OP_DIV, 5, 6, 7, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_DIV, mx, mn, -7, 0, 0, 0, 1));
    pending_reqs.push_back(make_req(OP_DIV, mn, 3, -3, 0, 0, 0, -1));
    pending_reqs.push_back(make_req(OP_DOT, mx, mx, mx, mx, mx, mx, 0));
    pending_reqs.push_back(make_req(OP_DOT, mn, mn, mn, mn, mn, mn, 0));
    pending_reqs.push_back(make_req(OP_DOT, -1, 3, 0, 1, 1, 0, 0));
    pending_reqs.push_back(make_req(OP_CROSS, mx, mn, mx, mn, mx, mn, 0));
    pending_reqs.push_back(make_req(OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0));
    pending_reqs.push_back(make_req(OP_LENSQ, mn, mn, mn, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_LENSQ, 3, -4, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_LEN, mn, mn, mn, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_LEN, 3, 4, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_NORM, 0, 0, 0, 1, 1, 1, 1));
    pending_reqs.push_back(make_req(OP_NORM, mn, mx, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_NORM, 0, 0, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_EQUAL, mx, mn, 7, mx, mn, 7, 0));
    pending_reqs.push_back(make_req(OP_EQUAL, mx, mn, 7, mx, mn, 6, 0));
    pending_reqs.push_back(make_req(4'd10, mx, mn, 1, 2, 3, 4, 5));
    pending_reqs.push_back(make_req(4'd15, -1, -1, -1, -1, -1, -1, -1));
    for (int i = 0; i < 1800; i++) begin
      q.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
      q.a_x = rand_word(); q.a_y = rand_word(); q.a_z = rand_word();
      if (q.op == OP_EQUAL && $urandom_range(0, 1)) begin
        // Mostly-equal vectors so that both outcomes are common.
        q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
        if ($urandom_range(0, 2) == 0) q.b_z = q.b_z ^ (32'sd1 << $urandom_range(0, 31));
      end else begin
        q.b_x = rand_word(); q.b_y = rand_word(); q.b_z = rand_word();
      end
      q.scalar_in = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
      pending_reqs.push_back(q);
    end
    quiet_from = pending_reqs.size() - 200;
    stim_done = 1;
  end

  // Driver: a request is taken at an edge where start is high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_vector_op(in_item));
        reqs_sent = reqs_sent + 1;
      end
      if (start && busy) begin
        // Hold the request until it is taken.
      end else if (idle_left > 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0 && stim_done &&
                   (reqs_sent >= quiet_from || $urandom_range(0, 9) != 0)) begin
        start <= 1'b1;
        in_item <= pending_reqs.pop_front();
      end else begin
        if (pending_reqs.size() > 0 && reqs_sent < quiet_from)
          idle_left = $urandom_range(0, 7);
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", out_result);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_result.r_x !== exp_r.r_x) begin
          $error("r_x expected %h actual %h", exp_r.r_x, out_result.r_x);
          fail_count++;
        end
        if (out_result.r_y !== exp_r.r_y) begin
          $error("r_y expected %h actual %h", exp_r.r_y, out_result.r_y);
          fail_count++;
        end
        if (out_result.r_z !== exp_r.r_z) begin
          $error("r_z expected %h actual %h", exp_r.r_z, out_result.r_z);
          fail_count++;
        end
        if (out_result.r_scalar !== exp_r.r_scalar) begin
          $error("r_scalar expected %h actual %h", exp_r.r_scalar, out_result.r_scalar);
          fail_count++;
        end
        if (out_result.is_equal !== exp_r.is_equal) begin
          $error("is_equal expected %b actual %b", exp_r.is_equal, out_result.is_equal);
          fail_count++;
        end
        if (out_result.status !== exp_r.status) begin
          $error("status expected %d actual %d", exp_r.status, out_result.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    @(posedge clk);
    while (pending_reqs.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    // Drain the pipeline to catch any stray result.
    repeat (120) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("vec3_fixed_point_alu_unit verification clean");
    end else begin
      $display("vec3_fixed_point_alu_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("vec3_fixed_point_alu_unit verification failed");
    $finish;
  end

endmodule
